// ----- design/spq_pkg.sv -----
// Shared types and constants for the stable sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int PRIO_W_DEF = 8;
    localparam int INFO_W     = 8;
    localparam int CNT_W      = 5;
    localparam int CAP_RESET  = 16;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status_code;

    typedef struct packed {
        logic               out_valid;
        t_status_code       code;
        logic [CNT_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
    } t_res_stat;

endpackage

// ----- design/spq_slot_ram.sv -----
// Slot storage: one write port and one read port with registered read data.
module spq_slot_ram #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int WIDTH = spq_pkg::PRIO_W_DEF + spq_pkg::INFO_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/spq_ctrl.sv -----
// Sequencer: queue indices and one compare-and-move step per cycle for insertion.
module spq_ctrl #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_W_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [spq_pkg::CNT_W-1:0]              i_cap,
    input  logic                                   i_clr,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic [PRIO_WIDTH-1:0]                  i_prio,
    input  logic [spq_pkg::INFO_W-1:0]             i_info,
    output logic                                   o_we,
    output logic [$clog2(DEPTH)-1:0]               o_waddr,
    output logic [PRIO_WIDTH+spq_pkg::INFO_W-1:0]  o_wdata,
    output logic [$clog2(DEPTH)-1:0]               o_raddr,
    input  logic [PRIO_WIDTH+spq_pkg::INFO_W-1:0]  i_rdata,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic [PRIO_WIDTH-1:0]                  o_res_prio,
    output logic [spq_pkg::INFO_W-1:0]             o_res_info,
    output spq_pkg::t_res_stat                     o_res_stat
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = ((IDX_W > spq_pkg::CNT_W) ? IDX_W : spq_pkg::CNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DEQ   = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [IDX_W-1:0]            r_head, n_head;
    logic [spq_pkg::CNT_W-1:0]   r_held, n_held;
    logic [IDX_W-1:0]            r_cur, n_cur;
    logic [PRIO_WIDTH-1:0]       r_new_prio, n_new_prio;
    logic [spq_pkg::INFO_W-1:0]  r_new_info, n_new_info;
    logic [PRIO_WIDTH-1:0]       r_prio, n_prio;
    logic [spq_pkg::INFO_W-1:0]  r_info, n_info;
    logic                        r_valid, n_valid;
    spq_pkg::t_status_code       r_status, n_status;

    logic [SUM_W-1:0]            w_cap_ext;
    logic [SUM_W-1:0]            w_tail_sum;
    logic [IDX_W-1:0]            w_tail;
    logic [IDX_W-1:0]            w_ins;
    logic [SUM_W-1:0]            w_head_inc;
    logic [IDX_W-1:0]            w_head_next;
    logic [IDX_W-1:0]            w_cur_prev;
    logic [IDX_W-1:0]            w_cur_prev2;
    logic [PRIO_WIDTH-1:0]       w_rd_prio;
    logic                        w_move;

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] idx,
                                                 input logic [SUM_W-1:0] cap);
        if (idx == '0) begin
            return IDX_W'(cap - SUM_W'(1));
        end
        return idx - IDX_W'(1);
    endfunction

    assign w_cap_ext   = SUM_W'(i_cap);
    assign w_tail_sum  = SUM_W'(r_head) + SUM_W'(r_held);
    assign w_tail      = (w_tail_sum >= w_cap_ext) ? IDX_W'(w_tail_sum - w_cap_ext)
                                                   : IDX_W'(w_tail_sum);
    assign w_ins       = (r_held == '0) ? '0 : w_tail;
    assign w_head_inc  = SUM_W'(r_head) + SUM_W'(1);
    assign w_head_next = (w_head_inc >= w_cap_ext) ? '0 : IDX_W'(w_head_inc);
    assign w_cur_prev  = f_prev(r_cur, w_cap_ext);
    assign w_cur_prev2 = f_prev(w_cur_prev, w_cap_ext);
    assign w_rd_prio   = i_rdata[PRIO_WIDTH-1:0];
    assign w_move      = (r_cur != r_head) && (r_new_prio < w_rd_prio);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_held     = r_held;
        n_cur      = r_cur;
        n_new_prio = r_new_prio;
        n_new_info = r_new_info;
        n_prio     = r_prio;
        n_info     = r_info;
        n_valid    = r_valid;
        n_status   = r_status;
        o_we       = 1'b0;
        o_waddr    = r_cur;
        o_wdata    = {r_new_info, r_new_prio};
        o_raddr    = w_cur_prev;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_prio   = '0;
                    n_info   = '0;
                    n_valid  = 1'b0;
                    n_status = spq_pkg::ST_OK;
                    if (i_req_type == spq_pkg::REQ_DEQ) begin
                        if (r_held == '0) begin
                            n_status = spq_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_raddr = r_head;
                            n_held  = r_held - spq_pkg::CNT_W'(1);
                            n_head  = (r_held == spq_pkg::CNT_W'(1)) ? '0 : w_head_next;
                            n_state = S_DEQ;
                        end
                    end else begin
                        if (r_held >= i_cap) begin
                            n_status = spq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_new_prio = i_prio;
                            n_new_info = i_info;
                            n_held     = r_held + spq_pkg::CNT_W'(1);
                            if (r_held == '0) begin
                                n_head = '0;
                            end
                            n_cur   = w_ins;
                            o_raddr = f_prev(w_ins, w_cap_ext);
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_DEQ: begin
                n_prio  = i_rdata[PRIO_WIDTH-1:0];
                n_info  = i_rdata[PRIO_WIDTH +: spq_pkg::INFO_W];
                n_valid = 1'b1;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                o_we = 1'b1;
                if (w_move) begin
                    o_wdata = i_rdata;
                    n_cur   = w_cur_prev;
                    o_raddr = w_cur_prev2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_clr) begin
            n_head = '0;
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_new_prio <= n_new_prio;
        r_new_info <= n_new_info;
        r_prio     <= n_prio;
        r_info     <= n_info;
        r_valid    <= n_valid;
        r_status   <= n_status;
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res_prio          = r_prio;
    assign o_res_info          = r_info;
    assign o_res_stat.out_valid = r_valid;
    assign o_res_stat.code     = r_status;
    assign o_res_stat.count    = r_held;
    assign o_res_stat.is_empty = (r_held == '0);
    assign o_res_stat.is_full  = (r_held == i_cap);

    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= i_cap)
        else $error("held count above capacity");

    a_deq_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |=> (r_state == S_DONE && r_valid))
        else $error("dequeue did not finish with an entry");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_res_ready) |=> (r_state == S_IDLE))
        else $error("result transfer did not release the sequencer");

    a_shift_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (!r_valid && r_status == spq_pkg::ST_OK))
        else $error("insertion walk with a bad result status");

endmodule

// ----- design/stable_sorted_priority_queue_core.sv -----
// Enqueue: an accepted request walks S_SHIFT, one compare-and-move step per entry moved
// (0 to capacity - 1); a dequeue reads its slot in S_DEQ; a flagged request goes straight
// to S_DONE. One request at a time; the next transfer is taken in the cycle after the result
// leaves the sequencer. A registered output stage lets a new request start while a result
// waits downstream. Synchronous active-low reset empties the queue and sets capacity to
// min(16, DEPTH).
module stable_sorted_priority_queue_core #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_W_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [spq_pkg::CNT_W-1:0]              i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // entry_prio, entry_info
    input  logic [((PRIO_WIDTH+spq_pkg::INFO_W+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_prio, out_info, status, count, is_empty, is_full
    output logic [((PRIO_WIDTH+spq_pkg::INFO_W+spq_pkg::CNT_W+4+7)/8)*8-1:0] m_axis_tdata,
    // out_valid
    output logic                                   m_axis_tuser
);

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int ENTRY_W   = PRIO_WIDTH + spq_pkg::INFO_W;
    localparam int M_TDATA_W = ((PRIO_WIDTH + spq_pkg::INFO_W + spq_pkg::CNT_W + 4 + 7) / 8) * 8;
    localparam logic [spq_pkg::CNT_W-1:0] CAP_INIT =
        (DEPTH < spq_pkg::CAP_RESET) ? spq_pkg::CNT_W'(DEPTH) : spq_pkg::CNT_W'(spq_pkg::CAP_RESET);

    logic [spq_pkg::CNT_W-1:0]  r_cap;
    logic                       r_out_valid;
    logic [PRIO_WIDTH-1:0]      r_out_prio;
    logic [spq_pkg::INFO_W-1:0] r_out_info;
    spq_pkg::t_res_stat         r_out_stat;

    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic [ENTRY_W-1:0]         w_wdata;
    logic [IDX_W-1:0]           w_raddr;
    logic [ENTRY_W-1:0]         w_rdata;
    logic                       w_res_valid;
    logic                       w_res_ready;
    logic [PRIO_WIDTH-1:0]      w_res_prio;
    logic [spq_pkg::INFO_W-1:0] w_res_info;
    spq_pkg::t_res_stat         w_res_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_INIT;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                r_cap <= spq_pkg::CNT_W'(1);
            end else if (32'(i_cfg_wdata) > DEPTH) begin
                r_cap <= spq_pkg::CNT_W'(DEPTH);
            end else begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    spq_ctrl #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_clr       (i_cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_prio      (s_axis_tdata[PRIO_WIDTH-1:0]),
        .i_info      (s_axis_tdata[PRIO_WIDTH +: spq_pkg::INFO_W]),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_prio  (w_res_prio),
        .o_res_info  (w_res_info),
        .o_res_stat  (w_res_stat)
    );

    spq_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_prio <= w_res_prio;
            r_out_info <= w_res_info;
            r_out_stat <= w_res_stat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_stat.out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_stat.is_full, r_out_stat.is_empty,
                                       r_out_stat.count, r_out_stat.code,
                                       r_out_info, r_out_prio});

endmodule
